### sv/cda_pkg.sv
// Shared types, constants and helpers for the collision displacement accumulator.
`default_nettype none

package cda_pkg;

    localparam int PARTICLES = 1024;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = $clog2(PARTICLES);
    localparam int CNT_W     = 16;
    localparam int WORD_W    = 3 * 32 + CNT_W;
    localparam int SCALE_W   = 32 + FRAC_BITS;
    localparam int HALF_W    = SCALE_W / 2;
    localparam int U_W       = FRAC_BITS + 1;

    localparam logic [2:0] MODE_CLEAR    = 3'd0;
    localparam logic [2:0] MODE_PAIR     = 3'd1;
    localparam logic [2:0] MODE_READ     = 3'd2;
    localparam logic [2:0] MODE_SPECULAR = 3'd3;
    localparam logic [2:0] MODE_DIFFUSE  = 3'd4;
    localparam logic [2:0] MODE_AXIS     = 3'd5;
    localparam logic [2:0] MODE_CLR_ALL  = 3'd6;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNZEROED = 2'd1;
    localparam logic [1:0] ERR_ZERO_LEN = 2'd2;
    localparam logic [1:0] ERR_MODE     = 2'd3;

    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef enum logic {
        IU_DIV,
        IU_SQRT
    } iu_op_t;

    typedef struct packed {
        logic   start;
        iu_op_t op;
    } iu_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/cda_iter.sv
// Bit-serial unit: 64/32 restoring divide or 64-bit integer square root.
`default_nettype none

module cda_iter (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire cda_pkg::iu_req_t req,
    input  wire logic [63:0]     num,
    input  wire logic [31:0]     den,
    output logic                 done,
    output logic [63:0]          result
);
    import cda_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    iu_op_t      op_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [35:0] rem_reg;
    logic [63:0] quo_reg;

    logic [32:0] div_rem;
    logic        div_ge;
    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        div_rem  = {rem_reg[31:0], num_reg[63]};
        div_ge   = div_rem >= {1'b0, den_reg};
        sq_rem   = {rem_reg[33:0], num_reg[63:62]};
        sq_trial = {2'b00, quo_reg[31:0], 2'b01};
        sq_ge    = sq_rem >= sq_trial;
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (!busy_reg) begin
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= (req.op == IU_DIV) ? 6'd63 : 6'd31;
            end
        end else begin
            if (op_reg == IU_DIV) begin
                rem_reg <= {3'b000, div_ge ? div_rem - {1'b0, den_reg} : div_rem};
                quo_reg <= {quo_reg[62:0], div_ge};
                num_reg <= {num_reg[62:0], 1'b0};
            end else begin
                rem_reg <= sq_ge ? sq_rem - sq_trial : sq_rem;
                quo_reg <= {quo_reg[62:0], sq_ge};
                num_reg <= {num_reg[61:0], 2'b00};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = quo_reg;

endmodule

`default_nettype wire

### sv/collision_displacement_accumulator.sv
// Top level: per-particle velocity/count store with collision and wall updates.
//
//   channel   direction  handshake        payload
//   s_        in         s_valid/s_ready  mode, indices, pre/post velocity, diameter
//   m_        out        m_valid/m_ready  vel_x/y/z, hit_count, error_code
//   cfg_      in         cfg_wr_en        time_step (cfg_wr_data)
//
// One beat at a time; diffuse and pair collision run longest, their time set by the
// bit-serial divide/sqrt unit (one bit per cycle, up to 5 runs per item).
// Reset and clear-all sweep the 1024-entry store, one entry per cycle, with s_ready low.
// The result register frees the input side; a stalled m_ready holds the next result.
`default_nettype none

module collision_displacement_accumulator (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_mode,
    input  wire logic [9:0]         s_first_index,
    input  wire logic [9:0]         s_second_index,
    input  wire logic signed [31:0] s_pre_x,
    input  wire logic signed [31:0] s_pre_y,
    input  wire logic signed [31:0] s_pre_z,
    input  wire logic signed [31:0] s_post_x,
    input  wire logic signed [31:0] s_post_y,
    input  wire logic signed [31:0] s_post_z,
    input  wire logic [31:0]        s_diameter,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_vel_x,
    output logic signed [31:0]      m_vel_y,
    output logic signed [31:0]      m_vel_z,
    output logic [15:0]             m_hit_count,
    output logic [1:0]              m_error_code,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data
);
    import cda_pkg::*;

    typedef enum logic [4:0] {
        ST_SWEEP, ST_IDLE, ST_LD_I, ST_LD_J, ST_EXEC,
        ST_SQ_MUL, ST_SQ_ACC,
        ST_P_NORM, ST_P_SCALE, ST_P_U, ST_P_M0, ST_P_M1, ST_P_M2, ST_P_UPD,
        ST_S_MUL, ST_S_ACC, ST_S_TW, ST_S_MUL2, ST_S_UPD,
        ST_D_L, ST_D_M, ST_D_MUL, ST_D_DS, ST_D_DW,
        ST_WR_I, ST_WR_J, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SQ_A,
        SQ_V,
        SQ_N
    } sq_sel_t;

    state_t state_reg;
    sq_sel_t sel_reg;

    logic [WORD_W-1:0] mem [PARTICLES];
    logic [WORD_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [31:0]        time_step_reg;
    logic [2:0]         mode_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [1:0]         ax_reg;
    logic signed [31:0] pre_reg [3];
    logic signed [31:0] post_reg [3];
    logic [31:0]        diam_reg;
    logic signed [31:0] vi_reg [3];
    logic signed [31:0] vj_reg [3];
    logic [CNT_W-1:0]   ci_reg;
    logic [CNT_W-1:0]   cj_reg;
    logic [CNT_W-1:0]   wci_reg;
    logic [CNT_W-1:0]   wcj_reg;
    logic [CNT_W-1:0]   shown_reg;
    logic [1:0]         err_reg;
    logic [31:0]        a_reg [3];
    logic               dneg_reg [3];
    logic               same_reg;
    logic [1:0]         k_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        sn_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        tmp_reg;
    logic [63:0]        full_reg;
    logic [31:0]        n_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [U_W-1:0]     u_reg;
    logic signed [49:0] dot_reg;
    logic signed [31:0] tw_reg;
    logic [31:0]        l_reg;
    logic [31:0]        mn_reg;
    logic [IDX_W-1:0]   sweep_addr_reg;
    logic               sweep_out_reg;
    iu_req_t            iu_req_reg;
    logic [63:0]        iu_num_reg;
    logic [31:0]        iu_den_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_vel_x_reg;
    logic signed [31:0] m_vel_y_reg;
    logic signed [31:0] m_vel_z_reg;
    logic [CNT_W-1:0]   m_hit_count_reg;
    logic [1:0]         m_error_code_reg;

    logic        iu_done;
    logic [63:0] iu_res;

    cda_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iu_req_reg),
        .num     (iu_num_reg),
        .den     (iu_den_reg),
        .done    (iu_done),
        .result  (iu_res)
    );

    // combinational helpers
    logic signed [32:0] dd [3];
    logic [32:0]        ad [3];
    logic [32:0]        amax;
    logic [31:0]        ash [3];
    logic               unz_i;
    logic               unz_j;
    logic [CNT_W-1:0]   ci_inc;
    logic [CNT_W-1:0]   cj_inc;
    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [63:0]        mul_p;
    logic [63:0]        sum_sq;
    logic [SCALE_W-1:0] r_full;
    logic [32:0]        r_cap;
    logic signed [33:0] delta;
    logic signed [31:0] upd_i;
    logic signed [31:0] base_j;
    logic signed [31:0] upd_j;
    logic signed [63:0] s_term;
    logic               s_neg;
    logic signed [63:0] s_sterm;
    logic signed [63:0] dot_sum;
    logic signed [31:0] spec_v;
    logic signed [31:0] diff_v;
    logic signed [31:0] axis_v;
    logic [31:0]        tstep;
    logic [1:0]         k_nx;
    logic               s_fire;

    always_comb begin
        amax = '0;
        for (int k = 0; k < 3; k++) begin
            dd[k] = 33'(post_reg[k]) - 33'(pre_reg[k]);
            ad[k] = dd[k][32] ? 33'(-dd[k]) : 33'(dd[k]);
            if (ad[k] > amax) begin
                amax = ad[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            ash[k] = (amax[32] || amax[31]) ? ad[k][32:1] : ad[k][31:0];
        end
        unz_i  = (ci_reg == '0) && (vi_reg[0] != 0 || vi_reg[1] != 0 || vi_reg[2] != 0);
        unz_j  = (cj_reg == '0) && (vj_reg[0] != 0 || vj_reg[1] != 0 || vj_reg[2] != 0);
        ci_inc = inc_sat(ci_reg);
        cj_inc = inc_sat((i_reg == j_reg) ? ci_inc : cj_reg);
        k_nx   = k_reg + 1'b1;
        tstep  = (time_step_reg == '0) ? 32'd1 : time_step_reg;

        case (state_reg)
            ST_SQ_MUL: begin
                case (sel_reg)
                    SQ_A: begin
                        mul_x = a_reg[k_reg];
                        mul_y = a_reg[k_reg];
                    end
                    SQ_V: begin
                        mul_x = mag32(vi_reg[k_reg]);
                        mul_y = mag32(vi_reg[k_reg]);
                    end
                    default: begin
                        mul_x = mag32(pre_reg[k_reg]);
                        mul_y = mag32(pre_reg[k_reg]);
                    end
                endcase
            end
            ST_P_M0: begin
                mul_x = 32'(u_reg);
                mul_y = 32'(scale_reg[HALF_W-1:0]);
            end
            ST_P_M1: begin
                mul_x = 32'(u_reg);
                mul_y = 32'(scale_reg[SCALE_W-1:HALF_W]);
            end
            ST_S_MUL: begin
                mul_x = mag32(vi_reg[k_reg]);
                mul_y = mag32(pre_reg[k_reg]);
            end
            ST_S_MUL2: begin
                mul_x = mag32(tw_reg);
                mul_y = mag32(pre_reg[k_reg]);
            end
            ST_D_MUL: begin
                mul_x = mag32(pre_reg[k_reg]);
                mul_y = l_reg;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
        mul_p  = 64'(mul_x) * 64'(mul_y);
        sum_sq = acc_reg + prod_reg;

        r_full = full_reg[63:FRAC_BITS];
        r_cap  = (r_full > SCALE_W'(64'h1_0000_0000)) ? 33'h1_0000_0000 : r_full[32:0];
        delta  = dneg_reg[k_reg] ? 34'sd0 - signed'({1'b0, r_cap}) : signed'({1'b0, r_cap});
        upd_i  = sat32(64'(vi_reg[k_reg]) + 64'(delta));
        base_j = same_reg ? upd_i : vj_reg[k_reg];
        upd_j  = sat32(64'(base_j) - 64'(delta));

        s_term  = signed'(64'(prod_reg[63:FRAC_BITS]));
        s_neg   = (state_reg == ST_S_UPD) ? (tw_reg[31] ^ pre_reg[k_reg][31])
                                          : (vi_reg[k_reg][31] ^ pre_reg[k_reg][31]);
        s_sterm = s_neg ? 64'sd0 - s_term : s_term;
        dot_sum = 64'(dot_reg) + s_sterm;
        spec_v  = sat32(64'(vi_reg[k_reg]) - s_sterm);

        diff_v = sat32(pre_reg[k_reg][31] ? 64'sd0 - signed'(iu_res) : signed'(iu_res));
        axis_v = sat32(64'sd0 - 64'(vi_reg[ax_reg]));

        s_fire = s_valid && (state_reg == ST_IDLE);

        mem_we    = 1'b0;
        mem_waddr = i_reg;
        mem_wdata = {wci_reg, vi_reg[2], vi_reg[1], vi_reg[0]};
        case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = '0;
            end
            ST_WR_I: begin
                mem_we = 1'b1;
            end
            ST_WR_J: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = {wcj_reg, vj_reg[2], vj_reg[1], vj_reg[0]};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        mem_raddr = (state_reg == ST_LD_I) ? j_reg : s_first_index[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            sweep_addr_reg   <= '0;
            sweep_out_reg    <= 1'b0;
            time_step_reg    <= 32'd65536;
            iu_req_reg       <= '{start: 1'b0, op: IU_DIV};
            m_valid_reg      <= 1'b0;
        end else begin
            iu_req_reg.start <= 1'b0;
            if (cfg_wr_en) begin
                time_step_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SWEEP: begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    if (sweep_addr_reg == IDX_W'(PARTICLES - 1)) begin
                        state_reg <= sweep_out_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        mode_reg    <= s_mode;
                        i_reg       <= s_first_index[IDX_W-1:0];
                        j_reg       <= s_second_index[IDX_W-1:0];
                        ax_reg      <= s_second_index[1:0];
                        pre_reg[0]  <= s_pre_x;
                        pre_reg[1]  <= s_pre_y;
                        pre_reg[2]  <= s_pre_z;
                        post_reg[0] <= s_post_x;
                        post_reg[1] <= s_post_y;
                        post_reg[2] <= s_post_z;
                        diam_reg    <= s_diameter;
                        state_reg   <= ST_LD_I;
                    end
                end
                ST_LD_I: begin
                    vi_reg[0] <= mem_q_reg[31:0];
                    vi_reg[1] <= mem_q_reg[63:32];
                    vi_reg[2] <= mem_q_reg[95:64];
                    ci_reg    <= mem_q_reg[WORD_W-1:96];
                    same_reg  <= (i_reg == j_reg);
                    state_reg <= ST_LD_J;
                end
                ST_LD_J: begin
                    vj_reg[0] <= mem_q_reg[31:0];
                    vj_reg[1] <= mem_q_reg[63:32];
                    vj_reg[2] <= mem_q_reg[95:64];
                    cj_reg    <= mem_q_reg[WORD_W-1:96];
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    err_reg   <= ERR_OK;
                    shown_reg <= ci_reg;
                    wci_reg   <= ci_reg;
                    k_reg     <= '0;
                    acc_reg   <= '0;
                    dot_reg   <= '0;
                    case (mode_reg)
                        MODE_CLEAR: begin
                            for (int k = 0; k < 3; k++) vi_reg[k] <= '0;
                            wci_reg   <= '0;
                            state_reg <= ST_WR_I;
                        end
                        MODE_PAIR: begin
                            for (int k = 0; k < 3; k++) begin
                                a_reg[k]    <= ash[k];
                                dneg_reg[k] <= dd[k][32];
                            end
                            wci_reg <= ci_inc;
                            wcj_reg <= cj_inc;
                            sel_reg <= SQ_A;
                            if (unz_i || unz_j) begin
                                err_reg   <= ERR_UNZEROED;
                                state_reg <= ST_DONE;
                            end else if (amax == '0) begin
                                err_reg   <= ERR_ZERO_LEN;
                                state_reg <= ST_DONE;
                            end else begin
                                state_reg <= ST_SQ_MUL;
                            end
                        end
                        MODE_READ: begin
                            wci_reg   <= '0;
                            state_reg <= ST_WR_I;
                        end
                        MODE_SPECULAR: begin
                            state_reg <= ST_S_MUL;
                        end
                        MODE_DIFFUSE: begin
                            sel_reg   <= SQ_N;
                            state_reg <= ST_SQ_MUL;
                        end
                        MODE_AXIS: begin
                            if (ax_reg != AXIS_NONE) begin
                                vi_reg[ax_reg] <= axis_v;
                            end
                            state_reg <= ST_WR_I;
                        end
                        MODE_CLR_ALL: begin
                            for (int k = 0; k < 3; k++) vi_reg[k] <= '0;
                            sweep_addr_reg <= '0;
                            sweep_out_reg  <= 1'b1;
                            state_reg      <= ST_SWEEP;
                        end
                        default: begin
                            err_reg   <= ERR_MODE;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_SQ_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    acc_reg <= sum_sq;
                    k_reg   <= k_nx;
                    if (k_reg != 2'd2) begin
                        state_reg <= ST_SQ_MUL;
                    end else begin
                        case (sel_reg)
                            SQ_A: begin
                                iu_req_reg <= '{start: 1'b1, op: IU_SQRT};
                                iu_num_reg <= sum_sq;
                                state_reg  <= ST_P_NORM;
                            end
                            SQ_N: begin
                                sn_reg  <= sum_sq;
                                acc_reg <= '0;
                                k_reg   <= '0;
                                sel_reg <= SQ_V;
                                if (sum_sq == '0) begin
                                    err_reg   <= ERR_ZERO_LEN;
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_SQ_MUL;
                                end
                            end
                            default: begin
                                iu_req_reg <= '{start: 1'b1, op: IU_SQRT};
                                iu_num_reg <= sum_sq;
                                state_reg  <= ST_D_L;
                            end
                        endcase
                    end
                end
                ST_P_NORM: begin
                    if (iu_done) begin
                        n_reg      <= (iu_res == '0) ? 32'd1 : iu_res[31:0];
                        iu_req_reg <= '{start: 1'b1, op: IU_DIV};
                        iu_num_reg <= 64'(diam_reg) << FRAC_BITS;
                        iu_den_reg <= tstep;
                        state_reg  <= ST_P_SCALE;
                    end
                end
                ST_P_SCALE: begin
                    if (iu_done) begin
                        scale_reg  <= iu_res[SCALE_W-1:0];
                        k_reg      <= '0;
                        iu_req_reg <= '{start: 1'b1, op: IU_DIV};
                        iu_num_reg <= 64'(a_reg[0]) << FRAC_BITS;
                        iu_den_reg <= n_reg;
                        state_reg  <= ST_P_U;
                    end
                end
                ST_P_U: begin
                    if (iu_done) begin
                        u_reg     <= iu_res[U_W-1:0];
                        state_reg <= ST_P_M0;
                    end
                end
                ST_P_M0: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_P_M1;
                end
                ST_P_M1: begin
                    tmp_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= ST_P_M2;
                end
                ST_P_M2: begin
                    full_reg  <= tmp_reg + (prod_reg << HALF_W);
                    state_reg <= ST_P_UPD;
                end
                ST_P_UPD: begin
                    vi_reg[k_reg] <= upd_i;
                    vj_reg[k_reg] <= upd_j;
                    k_reg         <= k_nx;
                    if (k_reg == 2'd2) begin
                        state_reg <= ST_WR_I;
                    end else begin
                        iu_req_reg <= '{start: 1'b1, op: IU_DIV};
                        iu_num_reg <= 64'(a_reg[k_nx]) << FRAC_BITS;
                        iu_den_reg <= n_reg;
                        state_reg  <= ST_P_U;
                    end
                end
                ST_S_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_S_ACC;
                end
                ST_S_ACC: begin
                    dot_reg <= dot_sum[49:0];
                    k_reg   <= k_nx;
                    state_reg <= (k_reg == 2'd2) ? ST_S_TW : ST_S_MUL;
                end
                ST_S_TW: begin
                    tw_reg    <= sat32(64'(dot_reg) <<< 1);
                    k_reg     <= '0;
                    state_reg <= ST_S_MUL2;
                end
                ST_S_MUL2: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_S_UPD;
                end
                ST_S_UPD: begin
                    vi_reg[k_reg] <= spec_v;
                    k_reg         <= k_nx;
                    state_reg     <= (k_reg == 2'd2) ? ST_WR_I : ST_S_MUL2;
                end
                ST_D_L: begin
                    if (iu_done) begin
                        l_reg      <= iu_res[31:0];
                        iu_req_reg <= '{start: 1'b1, op: IU_SQRT};
                        iu_num_reg <= sn_reg;
                        state_reg  <= ST_D_M;
                    end
                end
                ST_D_M: begin
                    if (iu_done) begin
                        mn_reg    <= iu_res[31:0];
                        k_reg     <= '0;
                        state_reg <= ST_D_MUL;
                    end
                end
                ST_D_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_D_DS;
                end
                ST_D_DS: begin
                    iu_req_reg <= '{start: 1'b1, op: IU_DIV};
                    iu_num_reg <= prod_reg;
                    iu_den_reg <= mn_reg;
                    state_reg  <= ST_D_DW;
                end
                ST_D_DW: begin
                    if (iu_done) begin
                        vi_reg[k_reg] <= diff_v;
                        k_reg         <= k_nx;
                        state_reg     <= (k_reg == 2'd2) ? ST_WR_I : ST_D_MUL;
                    end
                end
                ST_WR_I: begin
                    if (mode_reg == MODE_PAIR) begin
                        shown_reg <= same_reg ? wcj_reg : wci_reg;
                        state_reg <= ST_WR_J;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_WR_J: begin
                    if (same_reg) begin
                        for (int k = 0; k < 3; k++) vi_reg[k] <= vj_reg[k];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    sweep_out_reg <= 1'b0;
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_vel_x_reg      <= vi_reg[0];
                        m_vel_y_reg      <= vi_reg[1];
                        m_vel_z_reg      <= vi_reg[2];
                        m_hit_count_reg  <= shown_reg;
                        m_error_code_reg <= err_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_vel_x      = m_vel_x_reg;
    assign m_vel_y      = m_vel_y_reg;
    assign m_vel_z      = m_vel_z_reg;
    assign m_hit_count  = m_hit_count_reg;
    assign m_error_code = m_error_code_reg;

endmodule

`default_nettype wire

### tb/sv/tb_collision_displacement_accumulator.sv
// Testbench for collision_displacement_accumulator: random and directed beats, checked.
`default_nettype none

import cda_pkg::*;

typedef struct {
    logic [2:0]         mode;
    logic [9:0]         first;
    logic [9:0]         second;
    logic signed [31:0] pre [3];
    logic signed [31:0] post [3];
    logic [31:0]        diam;
} coll_beat_t;

typedef struct {
    logic signed [31:0] vel [3];
    logic [15:0]        hits;
    logic [1:0]         err;
} coll_result_t;

class particle_ledger;
    logic signed [31:0] vel_tab [PARTICLES][3];
    logic [15:0]        hit_tab [PARTICLES];
    logic [31:0]        step_q;
    coll_result_t       due_results [$];
    int                 mismatches;
    int                 results_seen;
    int                 mode_seen [8];
    int                 err_seen [4];

    function new();
        for (int p = 0; p < PARTICLES; p++) begin
            wipe(p);
        end
        step_q = 32'd65536;
        mismatches = 0;
        results_seen = 0;
        foreach (mode_seen[m]) mode_seen[m] = 0;
        foreach (err_seen[e]) err_seen[e] = 0;
    endfunction

    function void wipe(int p);
        for (int k = 0; k < 3; k++) vel_tab[p][k] = '0;
        hit_tab[p] = '0;
    endfunction

    function logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function longint unsigned abs64(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function longint qmul(longint a, longint b);
        longint unsigned p;
        p = (abs64(a) * abs64(b)) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function bit stale(int p);
        return hit_tab[p] == 0 &&
               (vel_tab[p][0] != 0 || vel_tab[p][1] != 0 || vel_tab[p][2] != 0);
    endfunction

    function logic [1:0] collide(int i, int j, coll_beat_t b);
        longint d [3];
        longint unsigned a [3];
        longint unsigned mx, ss, n, sc, t, u;
        logic [127:0] p;
        longint dl;
        if (stale(i) || stale(j)) return ERR_UNZEROED;
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(b.post[k]) - longint'(b.pre[k]);
            a[k] = abs64(d[k]);
            if (a[k] > mx) mx = a[k];
        end
        if (mx == 0) return ERR_ZERO_LEN;
        ss = 0;
        for (int k = 0; k < 3; k++) begin
            if (mx >= (64'd1 << 31)) a[k] >>= 1;
            ss += a[k] * a[k];
        end
        n = root64(ss);
        if (n == 0) n = 1;
        t = (step_q == 0) ? 1 : step_q;
        sc = ({32'd0, b.diam} << FRAC_BITS) / t;
        for (int k = 0; k < 3; k++) begin
            u = (a[k] << FRAC_BITS) / n;
            p = (128'(u) * 128'(sc)) >> FRAC_BITS;
            if (p > (128'd1 << 32)) p = 128'd1 << 32;
            dl = d[k] < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
            vel_tab[i][k] = clamp32(longint'(vel_tab[i][k]) + dl);
            vel_tab[j][k] = clamp32(longint'(vel_tab[j][k]) - dl);
        end
        if (hit_tab[i] != 16'hffff) hit_tab[i]++;
        if (hit_tab[j] != 16'hffff) hit_tab[j]++;
        return ERR_OK;
    endfunction

    function void note_beat(coll_beat_t b);
        coll_result_t r;
        int i, j, ax;
        longint nv [3];
        longint dot, tw;
        longint unsigned sv, sn, l, mn;
        i = b.first % PARTICLES;
        j = b.second % PARTICLES;
        r.err = ERR_OK;
        r.hits = hit_tab[i];
        for (int k = 0; k < 3; k++) nv[k] = longint'(b.pre[k]);
        mode_seen[b.mode]++;
        case (b.mode)
            MODE_CLEAR: wipe(i);
            MODE_PAIR: begin
                r.err = collide(i, j, b);
                r.hits = hit_tab[i];
            end
            MODE_READ: hit_tab[i] = '0;
            MODE_SPECULAR: begin
                dot = 0;
                for (int k = 0; k < 3; k++) dot += qmul(vel_tab[i][k], nv[k]);
                tw = clamp32(dot * 2);
                for (int k = 0; k < 3; k++)
                    vel_tab[i][k] = clamp32(longint'(vel_tab[i][k]) - qmul(tw, nv[k]));
            end
            MODE_DIFFUSE: begin
                sv = 0;
                sn = 0;
                for (int k = 0; k < 3; k++) begin
                    sv += abs64(vel_tab[i][k]) * abs64(vel_tab[i][k]);
                    sn += abs64(nv[k]) * abs64(nv[k]);
                end
                mn = root64(sn);
                if (mn == 0) begin
                    r.err = ERR_ZERO_LEN;
                end else begin
                    l = root64(sv);
                    for (int k = 0; k < 3; k++) begin
                        sv = (abs64(nv[k]) * l) / mn;
                        vel_tab[i][k] = clamp32(nv[k] < 0 ? -longint'(sv) : longint'(sv));
                    end
                end
            end
            MODE_AXIS: begin
                ax = b.second[1:0];
                if (ax != AXIS_NONE)
                    vel_tab[i][ax] = clamp32(-longint'(vel_tab[i][ax]));
            end
            MODE_CLR_ALL: for (int p = 0; p < PARTICLES; p++) wipe(p);
            default: r.err = ERR_MODE;
        endcase
        for (int k = 0; k < 3; k++) r.vel[k] = vel_tab[i][k];
        due_results.push_back(r);
    endfunction

    function void check_beat(coll_result_t got);
        coll_result_t want;
        results_seen++;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: hits %0d err %0d",
                                           got.hits, got.err);
            return;
        end
        want = due_results.pop_front();
        err_seen[want.err]++;
        if (got.vel != want.vel || got.hits != want.hits || got.err != want.err) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp vel %0d %0d %0d hits %0d err %0d",
                          " / got %0d %0d %0d hits %0d err %0d"},
                         want.vel[0], want.vel[1], want.vel[2], want.hits, want.err,
                         got.vel[0], got.vel[1], got.vel[2], got.hits, got.err);
        end
    endfunction
endclass

module tb_collision_displacement_accumulator;
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_mode = '0;
    logic [9:0]         s_first_index = '0;
    logic [9:0]         s_second_index = '0;
    logic signed [31:0] s_pre_x = '0, s_pre_y = '0, s_pre_z = '0;
    logic signed [31:0] s_post_x = '0, s_post_y = '0, s_post_z = '0;
    logic [31:0]        s_diameter = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_vel_x, m_vel_y, m_vel_z;
    logic [15:0]        m_hit_count;
    logic [1:0]         m_error_code;
    logic               cfg_wr_en = 1'b0;
    logic [31:0]        cfg_wr_data = '0;

    particle_ledger ledger = new();
    int stall_mode = 0;
    int sent = 0;

    collision_displacement_accumulator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_first_index(s_first_index), .s_second_index(s_second_index),
        .s_pre_x(s_pre_x), .s_pre_y(s_pre_y), .s_pre_z(s_pre_z),
        .s_post_x(s_post_x), .s_post_y(s_post_y), .s_post_z(s_post_z),
        .s_diameter(s_diameter),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vel_x(m_vel_x), .m_vel_y(m_vel_y), .m_vel_z(m_vel_z),
        .m_hit_count(m_hit_count), .m_error_code(m_error_code),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // accepted beats feed the predictor and the checker
    always @(posedge aclk) begin
        coll_beat_t   b;
        coll_result_t r;
        if (aresetn && s_valid && s_ready) begin
            b.mode = s_mode;
            b.first = s_first_index;
            b.second = s_second_index;
            b.pre[0] = s_pre_x;
            b.pre[1] = s_pre_y;
            b.pre[2] = s_pre_z;
            b.post[0] = s_post_x;
            b.post[1] = s_post_y;
            b.post[2] = s_post_z;
            b.diam = s_diameter;
            ledger.note_beat(b);
        end
        if (aresetn && m_valid && m_ready) begin
            r.vel[0] = m_vel_x;
            r.vel[1] = m_vel_y;
            r.vel[2] = m_vel_z;
            r.hits = m_hit_count;
            r.err = m_error_code;
            ledger.check_beat(r);
        end
    end

    // receiver stall pattern: m_ready always high, random, or mostly low, by regime
    always @(posedge aclk) begin
        int cyc;
        cyc = cyc + 1;
        if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send(coll_beat_t b);
        s_valid <= 1'b1;
        s_mode <= b.mode;
        s_first_index <= b.first;
        s_second_index <= b.second;
        s_pre_x <= b.pre[0];
        s_pre_y <= b.pre[1];
        s_pre_z <= b.pre[2];
        s_post_x <= b.post[0];
        s_post_y <= b.post[1];
        s_post_z <= b.post[2];
        s_diameter <= b.diam;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic pause(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_step(logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.step_q = v;
    endtask

    function automatic coll_beat_t beat(logic [2:0] m, int i, int j,
                                        longint p0, longint p1, longint p2,
                                        longint q0, longint q1, longint q2,
                                        logic [31:0] d);
        coll_beat_t b;
        b.mode = m;
        b.first = 10'(i);
        b.second = 10'(j);
        b.pre[0] = 32'(p0);
        b.pre[1] = 32'(p1);
        b.pre[2] = 32'(p2);
        b.post[0] = 32'(q0);
        b.post[1] = 32'(q1);
        b.post[2] = 32'(q2);
        b.diam = d;
        return b;
    endfunction

    function automatic logic signed [31:0] any_val();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic coll_beat_t rand_beat();
        coll_beat_t b;
        int pick;
        b.first = 10'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 7)
                                                   : $urandom_range(0, 1023));
        b.second = 10'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 1023));
        for (int k = 0; k < 3; k++) begin
            b.pre[k] = any_val();
            b.post[k] = any_val();
        end
        b.diam = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1 << 12, 1 << 18);
        pick = $urandom_range(0, 99);
        if (pick < 40) b.mode = MODE_PAIR;
        else if (pick < 50) b.mode = MODE_READ;
        else if (pick < 60) b.mode = MODE_SPECULAR;
        else if (pick < 70) b.mode = MODE_DIFFUSE;
        else if (pick < 80) b.mode = MODE_AXIS;
        else if (pick < 88) b.mode = MODE_CLEAR;
        else if (pick < 89) b.mode = MODE_CLR_ALL;
        else if (pick < 92) b.mode = 3'd7;
        else begin
            b.mode = 3'($urandom_range(0, 7));
            if (b.mode == MODE_CLR_ALL) b.mode = MODE_READ;
            b.first = 10'($urandom);
            b.second = 10'($urandom);
            for (int k = 0; k < 3; k++) begin
                b.pre[k] = $urandom;
                b.post[k] = $urandom;
            end
            b.diam = $urandom;
        end
        if (b.mode == MODE_SPECULAR && $urandom_range(0, 2) != 0) begin
            b.pre[0] = 32'sd65536;
            b.pre[1] = 32'sd0;
            b.pre[2] = 32'sd0;
        end
        return b;
    endfunction

    initial begin
        logic [31:0] steps [5];
        int burst;
        steps[0] = 32'd65536;
        steps[1] = 32'd1;
        steps[2] = 32'hffffffff;
        steps[3] = $urandom_range(1, 32'h7fffffff);
        steps[4] = 32'h00008000;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_step(steps[0]);

        // directed
        send(beat(MODE_PAIR, 0, 1, 32'sh80000000, 32'sh80000000, 0,
                  32'sh7fffffff, 32'sh7fffffff, 0, 32'hffffffff));
        send(beat(MODE_PAIR, 0, 1, 5, 6, 7, 5, 6, 7, 1 << 16));
        send(beat(MODE_PAIR, 2, 2, 0, 0, 0, 1 << 16, -(1 << 16), 3 << 16, 2 << 16));
        send(beat(MODE_PAIR, 1023, 3, 0, 0, 0, -100, 200, 0, 0));
        send(beat(MODE_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_PAIR, 3, 4, 0, 0, 0, 1 << 16, 0, 0, 1 << 16));
        send(beat(MODE_PAIR, 4, 3, 0, 0, 0, 1 << 16, 0, 0, 1 << 16));
        send(beat(MODE_SPECULAR, 2, 0, 1 << 16, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_SPECULAR, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                  0, 0, 0, 0));
        send(beat(MODE_DIFFUSE, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_DIFFUSE, 2, 0, 0, 3 << 16, -(4 << 16), 0, 0, 0, 0));
        send(beat(MODE_AXIS, 0, 10'h3fc, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_AXIS, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_AXIS, 0, 2, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_AXIS, 0, 3, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_CLEAR, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
        send(beat(3'd7, 0, 1023, -1, -1, -1, -1, -1, -1, 32'hffffffff));
        send(beat(MODE_CLR_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(beat(MODE_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();

        // random phases, one time step each
        for (int ph = 0; ph < 5; ph++) begin
            set_step(steps[(ph + 1) % 5]);
            burst = 0;
            for (int n = 0; n < 380; n++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 30);
                    if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 40));
                end
                burst--;
                send(rand_beat());
            end
            drain();
        end
        repeat (400) @(posedge aclk);

        $display({"covered %0d beats; modes clear/pair/read/spec/diff/axis/all/bad:",
                  " %0d %0d %0d %0d %0d %0d %0d %0d"},
                 sent, ledger.mode_seen[0], ledger.mode_seen[1], ledger.mode_seen[2],
                 ledger.mode_seen[3], ledger.mode_seen[4], ledger.mode_seen[5],
                 ledger.mode_seen[6], ledger.mode_seen[7]);
        $display({"results %0d, error codes ok/unzeroed/zero-len/mode:",
                  " %0d %0d %0d %0d, mismatches %0d"},
                 ledger.results_seen, ledger.err_seen[0], ledger.err_seen[1],
                 ledger.err_seen[2], ledger.err_seen[3], ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.due_results.size() == 0) begin
            $display("tb_collision_displacement_accumulator: done, clean");
        end else begin
            $display("tb_collision_displacement_accumulator: done, errors");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("tb_collision_displacement_accumulator: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
